// ===== sv/sldist_pkg.sv =====
// sldist_pkg: shared types, constants and tables for the srgb lab color distance pipeline
`default_nettype none
package sldist_pkg;

  // default number of fraction bits of the distance output
  localparam int FRAC_BITS_DEF = 8;

  // pipeline geometry
  localparam int NUM_CH      = 6;   // x, y, z of color a, then of color b
  localparam int CUBE_STEPS  = 17;  // one cube-root bit per stage
  localparam int SQRT_W      = 60;  // radicand width of the distance root
  localparam int SQRT_STEPS  = SQRT_W / 2;

  // lab f() linear segment: at or below this the cube root is not used
  localparam logic [17:0] F_KNEE = 18'd580;
  // round(65536 * 16 / 116)
  localparam logic [16:0] F_OFFSET = 17'd9039;
  // ceil(2^32 / 1000), exact floor divide by 1000 for the linear segment range
  localparam logic [22:0] LIN_RECIP = 23'd4294968;

  // linear rgb to white-normalized xyz matrix, q16
  localparam logic [15:0] KXR = 16'((64'd2 * 4124 * 10 * 65536 + 64'd95047) / (64'd2 * 95047));
  localparam logic [15:0] KXG = 16'((64'd2 * 3576 * 10 * 65536 + 64'd95047) / (64'd2 * 95047));
  localparam logic [15:0] KXB = 16'((64'd2 * 1805 * 10 * 65536 + 64'd95047) / (64'd2 * 95047));
  localparam logic [15:0] KYR = 16'((64'd2 * 2126 * 65536 + 64'd10000) / (64'd2 * 10000));
  localparam logic [15:0] KYG = 16'((64'd2 * 7152 * 65536 + 64'd10000) / (64'd2 * 10000));
  localparam logic [15:0] KYB = 16'((64'd2 * 722 * 65536 + 64'd10000) / (64'd2 * 10000));
  localparam logic [15:0] KZR = 16'((64'd2 * 193 * 10 * 65536 + 64'd108883) / (64'd2 * 108883));
  localparam logic [15:0] KZG = 16'((64'd2 * 1192 * 10 * 65536 + 64'd108883) / (64'd2 * 108883));
  localparam logic [15:0] KZB = 16'((64'd2 * 9505 * 10 * 65536 + 64'd108883) / (64'd2 * 108883));

  typedef logic [15:0] coef_row_t [3];
  typedef coef_row_t coef_mat_t [3];
  localparam coef_mat_t KMAT = '{'{KXR, KXG, KXB}, '{KYR, KYG, KYB}, '{KZR, KZG, KZB}};

  // 2 * (255 * 12.92 * 10), rounding divisor of the low gamma segment
  localparam longint unsigned LOW_SEG_DIV = 64'd65892;
  // 255 * 1.055 * 1000, divisor of the gamma offset term
  localparam longint unsigned GAMMA_DIV = 64'd269025;

  // srgb gamma removal table, q16 linear value per 8-bit code
  typedef logic [16:0] lin_table_t [256];

  function automatic lin_table_t build_lin_table();
    lin_table_t tbl;
    longint unsigned tq;
    longint unsigned t2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned p;
    for (int c = 0; c < 256; c++) begin
      if (c <= 10) begin
        tbl[c] = 17'((longint'(2) * c * 655360 + 32946) / LOW_SEG_DIV);
      end else begin
        tq = ((longint'(1000) * c + 14025) * 65536) / GAMMA_DIV;
        t2 = (tq * tq) >> 16;
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          p = mid;
          for (int j = 0; j < 4; j++) begin
            p = (p * mid) >> 16;
          end
          if (p <= t2) begin
            lo = mid;
          end else begin
            hi = mid - 1;
          end
        end
        tbl[c] = 17'((t2 * lo) >> 16);
      end
    end
    return tbl;
  endfunction

  localparam lin_table_t LIN_TABLE = build_lin_table();

  // cube-root stage contents, plus the linear segment carried alongside
  typedef struct packed {
    logic [49:0] target;
    logic [16:0] q;
    logic [33:0] q2;
    logic [53:0] q3;
    logic        lin_seg;
    logic [22:0] lin;
  } cube_t;

  // one bit of the cube root; the first stage also finishes the linear segment
  function automatic cube_t cube_step(cube_t a, int k, bit first);
    cube_t r;
    logic [53:0] c3;
    logic [33:0] c2;
    logic [45:0] lin_prod;
    r = a;
    c3 = a.q3 + ((54'(a.q2) * 3) << k) + ((54'(a.q) * 3) << (2 * k)) + (54'(1) << (3 * k));
    c2 = a.q2 + (34'(a.q) << (k + 1)) + (34'(1) << (2 * k));
    if (c3 <= 54'(a.target)) begin
      r.q  = a.q | (17'(1) << k);
      r.q2 = c2;
      r.q3 = c3;
    end
    lin_prod = 46'(a.lin) * 46'(LIN_RECIP);
    if (first) begin
      r.lin = 23'(lin_prod >> 32) + 23'(F_OFFSET);
    end
    return r;
  endfunction

  // integer square root stage contents
  typedef struct packed {
    logic [SQRT_W-1:0] n;
    logic [SQRT_W-1:0] res;
  } sqrt_t;

  // one result bit of the restoring square root
  function automatic sqrt_t sqrt_step(sqrt_t a, int i);
    sqrt_t r;
    logic [SQRT_W-1:0] bitv;
    logic [SQRT_W-1:0] trial;
    bitv  = SQRT_W'(1) << (SQRT_W - 2 - 2 * i);
    trial = a.res + bitv;
    if (a.n >= trial) begin
      r.n   = a.n - trial;
      r.res = (a.res >> 1) + bitv;
    end else begin
      r.n   = a.n;
      r.res = a.res >> 1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/srgb_lab_color_distance.sv =====
// srgb_lab_color_distance: pipelined cie76 delta e between two 8-bit srgb colors
//
//  channel  | ports                                        | handshake
//  request  | red_a green_a blue_a red_b green_b blue_b    | start, taken when busy is low
//  result   | delta_e                                      | done strobe, one cycle
//
// one request per clock; busy is always low, so every start is taken.
// pipeline stages: gamma table, matrix multiply, matrix sum, cube-root setup,
// 17 cube-root bit stages per lab channel, four lab/square/sum stages,
// 30 square-root bit stages and an output scale/clamp stage.
// rst is synchronous and clears only the valid chain; data registers run free.
// the receiver cannot stall, so results leave as they finish.
`default_nettype none
module srgb_lab_color_distance
  import sldist_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  red_a,
  input  wire logic [7:0]  green_a,
  input  wire logic [7:0]  blue_a,
  input  wire logic [7:0]  red_b,
  input  wire logic [7:0]  green_b,
  input  wire logic [7:0]  blue_b,
  output logic             done,
  output logic [16:0]      delta_e
);

  localparam int LATENCY = 3 + 1 + CUBE_STEPS + 4 + SQRT_STEPS + 1;
  localparam int SHIFT   = 16 - FRAC_BITS;
  localparam longint unsigned CAP_RAW = longint'(300) << FRAC_BITS;
  localparam logic [16:0] OUT_CAP = (CAP_RAW < 64'h1FFFF) ? 17'(CAP_RAW) : 17'h1FFFF;

  logic [LATENCY-1:0] vld;

  logic [16:0] lin   [NUM_CH];
  logic [32:0] prod  [NUM_CH];
  logic [17:0] v     [NUM_CH];
  cube_t       cube  [CUBE_STEPS+1][NUM_CH];
  logic [16:0] f     [NUM_CH];

  logic signed [17:0] dl;
  logic signed [18:0] dx;
  logic signed [18:0] dz;
  logic signed [25:0] ml;
  logic signed [28:0] ma;
  logic signed [28:0] mb;
  logic [55:0] sq_l;
  logic [55:0] sq_a;
  logic [55:0] sq_b;
  sqrt_t       sroot [SQRT_STEPS+1];
  logic [SQRT_W-1:0] scaled;

  logic [7:0] pix [NUM_CH];

  assign busy = 1'b0;

  // component codes in channel order: r, g, b of a then of b
  assign pix[0] = red_a;
  assign pix[1] = green_a;
  assign pix[2] = blue_a;
  assign pix[3] = red_b;
  assign pix[4] = green_b;
  assign pix[5] = blue_b;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start && !busy};
    end
  end

  // gamma removal
  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      lin[c] <= LIN_TABLE[pix[c]];
    end
  end

  // matrix products, one per output row and input component
  logic [32:0] mp [2][3][3];
  always_ff @(posedge clk) begin
    for (int s = 0; s < 2; s++) begin
      for (int row = 0; row < 3; row++) begin
        for (int col = 0; col < 3; col++) begin
          mp[s][row][col] <= 33'(KMAT[row][col]) * 33'(lin[3 * s + col]);
        end
      end
    end
  end

  // matrix row sums with rounding
  always_ff @(posedge clk) begin
    for (int s = 0; s < 2; s++) begin
      for (int row = 0; row < 3; row++) begin
        v[3 * s + row] <= 18'((35'(mp[s][row][0]) + 35'(mp[s][row][1])
                               + 35'(mp[s][row][2]) + 35'd32768) >> 16);
      end
    end
  end

  // cube root setup and linear segment numerator
  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      cube[0][c].target  <= {v[c], 32'd0};
      cube[0][c].q       <= '0;
      cube[0][c].q2      <= '0;
      cube[0][c].q3      <= '0;
      cube[0][c].lin_seg <= (v[c] <= F_KNEE);
      cube[0][c].lin     <= 23'(23'(v[c][9:0]) * 23'd7787) + 23'd500;
    end
  end

  // cube root bit stages
  for (genvar s = 0; s < CUBE_STEPS; s++) begin : g_cube
    always_ff @(posedge clk) begin
      for (int c = 0; c < NUM_CH; c++) begin
        cube[s+1][c] <= cube_step(cube[s][c], CUBE_STEPS - 1 - s, s == 0);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      f[c] = cube[CUBE_STEPS][c].lin_seg ? cube[CUBE_STEPS][c].lin[16:0]
                                         : cube[CUBE_STEPS][c].q;
    end
  end

  // lab differences between the two colors
  always_ff @(posedge clk) begin
    dl <= $signed({1'b0, f[1]}) - $signed({1'b0, f[4]});
    dx <= ($signed({2'b0, f[0]}) - $signed({2'b0, f[1]}))
        - ($signed({2'b0, f[3]}) - $signed({2'b0, f[4]}));
    dz <= ($signed({2'b0, f[1]}) - $signed({2'b0, f[2]}))
        - ($signed({2'b0, f[4]}) - $signed({2'b0, f[5]}));
  end

  // lab scaling
  always_ff @(posedge clk) begin
    ml <= 26'(dl) * 26'sd116;
    ma <= 29'(dx) * 29'sd500;
    mb <= 29'(dz) * 29'sd200;
  end

  // squares of magnitudes
  always_ff @(posedge clk) begin
    logic [27:0] al;
    logic [27:0] aa;
    logic [27:0] ab;
    al = ml[25] ? 28'(-ml) : 28'(ml);
    aa = ma[28] ? 28'(-ma) : 28'(ma);
    ab = mb[28] ? 28'(-mb) : 28'(mb);
    sq_l <= 56'(al) * 56'(al);
    sq_a <= 56'(aa) * 56'(aa);
    sq_b <= 56'(ab) * 56'(ab);
  end

  // sum of squares into the root pipeline
  always_ff @(posedge clk) begin
    sroot[0].n   <= SQRT_W'(sq_l) + SQRT_W'(sq_a) + SQRT_W'(sq_b);
    sroot[0].res <= '0;
  end

  // square root bit stages
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    always_ff @(posedge clk) begin
      sroot[i+1] <= sqrt_step(sroot[i], i);
    end
  end

  // output scaling and clamp
  assign scaled = sroot[SQRT_STEPS].res >> SHIFT;

  always_ff @(posedge clk) begin
    if (scaled > SQRT_W'(OUT_CAP)) begin
      delta_e <= OUT_CAP;
    end else begin
      delta_e <= scaled[16:0];
    end
  end

  assign done = vld[LATENCY-1];

endmodule
`default_nettype wire

// ===== bench/srgb_lab_color_distance_tb.sv =====
// srgb_lab_color_distance_tb: self-checking bench for the srgb to lab color distance pipeline
`timescale 1ns / 100ps
`default_nettype none
module srgb_lab_color_distance_tb;
  import sldist_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic [7:0] ra, ga, ba, rb, gb, bb;
  } color_pair_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  red_a = '0, green_a = '0, blue_a = '0;
  logic [7:0]  red_b = '0, green_b = '0, blue_b = '0;
  logic        done;
  logic [16:0] delta_e;

  color_pair_t pair_queue[$];
  logic [16:0] distance_queue[$];
  bit          failed = 1'b0;
  bit          feeding_done = 1'b0;
  int          gap_left = 0;

  srgb_lab_color_distance #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .red_a(red_a), .green_a(green_a), .blue_a(blue_a),
    .red_b(red_b), .green_b(green_b), .blue_b(blue_b),
    .done(done), .delta_e(delta_e)
  );

  always #5 clk = ~clk;

  // gamma removal of one 8-bit code, q16 linear light
  function automatic longint unsigned linearize(logic [7:0] c);
    longint unsigned tq, t2, lo, hi, mid, p;
    if (c <= 8'd10) begin
      return (longint'(2) * c * 655360 + 32946) / (longint'(2) * 32946);
    end
    tq = ((longint'(1000) * c + 14025) * 65536) / 269025;
    t2 = (tq * tq) >> 16;
    lo = 0;
    hi = 65536;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      p = mid;
      repeat (4) p = (p * mid) >> 16;
      if (p <= t2) lo = mid;
      else hi = mid - 1;
    end
    return (t2 * lo) >> 16;
  endfunction

  // lab companding: exact cube root above the knee, linear segment at or below it
  function automatic longint lab_compand(longint unsigned v);
    longint unsigned lo, hi, mid, target;
    if (v > 580) begin
      target = v << 32;
      lo = 0;
      hi = 131071;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (mid * mid * mid <= target) lo = mid;
        else hi = mid - 1;
      end
      return longint'(lo);
    end
    return longint'((7787 * v + 500) / 1000 + 9039);
  endfunction

  // one color to lab, signed q16
  function automatic void color_to_lab(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8,
                                       output longint l, output longint a, output longint b);
    longint unsigned r, g, bl, x, y, z;
    longint fx, fy, fz;
    r  = linearize(r8);
    g  = linearize(g8);
    bl = linearize(b8);
    x  = (longint'(KXR) * r + longint'(KXG) * g + longint'(KXB) * bl + 32768) >> 16;
    y  = (longint'(KYR) * r + longint'(KYG) * g + longint'(KYB) * bl + 32768) >> 16;
    z  = (longint'(KZR) * r + longint'(KZG) * g + longint'(KZB) * bl + 32768) >> 16;
    fx = lab_compand(x);
    fy = lab_compand(y);
    fz = lab_compand(z);
    l = 116 * fy - 16 * 65536;
    a = 500 * (fx - fy);
    b = 200 * (fy - fz);
  endfunction

  // cie76 distance of a pair, scaled and clamped as the output port carries it
  function automatic logic [16:0] pair_distance(color_pair_t cp);
    longint la, aa, ba, lb, ab, bb, dl, da, db;
    longint unsigned sum, res, bitv, d, cap;
    color_to_lab(cp.ra, cp.ga, cp.ba, la, aa, ba);
    color_to_lab(cp.rb, cp.gb, cp.bb, lb, ab, bb);
    dl = la - lb;
    da = aa - ab;
    db = ba - bb;
    sum = dl * dl + da * da + db * db;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > sum) bitv >>= 2;
    while (bitv != 0) begin
      if (sum >= res + bitv) begin
        sum -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    d = res >> (16 - FRAC);
    cap = 300 << FRAC;
    if (cap > 64'h1FFFF) cap = 64'h1FFFF;
    if (d > cap) d = cap;
    return d[16:0];
  endfunction

  function automatic color_pair_t make_pair(int ra, int ga, int ba, int rb, int gb, int bb);
    color_pair_t cp;
    cp.ra = 8'(ra); cp.ga = 8'(ga); cp.ba = 8'(ba);
    cp.rb = 8'(rb); cp.gb = 8'(gb); cp.bb = 8'(bb);
    return cp;
  endfunction

  // random code, biased toward the gamma knee and the ends of the range
  function automatic logic [7:0] pick_code();
    unique case ($urandom_range(0, 5))
      0: return 8'($urandom_range(0, 14));
      1: return 8'($urandom_range(240, 255));
      default: return 8'($urandom);
    endcase
  endfunction

  // request driver: one pending request per start, random gap before each
  always @(posedge clk) begin
    color_pair_t cp;
    if (rst) begin
      start <= 1'b0;
      gap_left <= $urandom_range(0, 13);
    end else if (!(start && busy)) begin
      if (start) begin
        cp.ra = red_a; cp.ga = green_a; cp.ba = blue_a;
        cp.rb = red_b; cp.gb = green_b; cp.bb = blue_b;
        distance_queue.push_back(pair_distance(cp));
      end
      if (gap_left > 0 || pair_queue.size() == 0) begin
        start <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        cp = pair_queue.pop_front();
        start   <= 1'b1;
        red_a   <= cp.ra; green_a <= cp.ga; blue_a <= cp.ba;
        red_b   <= cp.rb; green_b <= cp.gb; blue_b <= cp.bb;
        // runs without gaps now and then
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      end
    end
  end

  // result monitor: compare each strobed distance with the oldest prediction
  always @(posedge clk) begin
    logic [16:0] want;
    if (!rst && done) begin
      if (distance_queue.size() == 0) begin
        $error("delta_e: unexpected result %0d", delta_e);
        failed = 1'b1;
      end else begin
        want = distance_queue.pop_front();
        if (delta_e !== want) begin
          $error("delta_e: expected %0d actual %0d", want, delta_e);
          failed = 1'b1;
        end
      end
    end
  end

  // stimulus
  initial begin
    int n;
    pair_queue.push_back(make_pair(0, 0, 0, 0, 0, 0));
    pair_queue.push_back(make_pair(255, 255, 255, 255, 255, 255));
    pair_queue.push_back(make_pair(0, 0, 0, 255, 255, 255));
    pair_queue.push_back(make_pair(255, 255, 255, 0, 0, 0));
    pair_queue.push_back(make_pair(255, 0, 0, 0, 255, 0));
    pair_queue.push_back(make_pair(0, 0, 255, 255, 255, 0));
    pair_queue.push_back(make_pair(0, 255, 0, 255, 0, 255));
    pair_queue.push_back(make_pair(10, 10, 10, 11, 11, 11));
    pair_queue.push_back(make_pair(10, 0, 0, 0, 0, 10));
    pair_queue.push_back(make_pair(1, 1, 1, 0, 0, 0));
    pair_queue.push_back(make_pair(20, 20, 20, 21, 21, 21));
    pair_queue.push_back(make_pair(0, 0, 255, 0, 255, 0));
    pair_queue.push_back(make_pair(170, 85, 85, 85, 170, 170));
    pair_queue.push_back(make_pair(128, 128, 128, 127, 127, 127));
    pair_queue.push_back(make_pair(255, 0, 255, 0, 255, 0));
    for (n = 0; n < 1100; n++) begin
      pair_queue.push_back(make_pair(pick_code(), pick_code(), pick_code(),
                                     pick_code(), pick_code(), pick_code()));
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // wait for the last request to be taken and every result to arrive
    while (pair_queue.size() != 0 || start) @(posedge clk);
    while (distance_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && distance_queue.size() == 0) begin
      $display("srgb_lab_color_distance_tb: PASS");
    end else begin
      $display("srgb_lab_color_distance_tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("srgb_lab_color_distance_tb: FAIL");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
sv/sldist_pkg.sv
sv/srgb_lab_color_distance.sv
bench/srgb_lab_color_distance_tb.sv
